// ===== src/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Ringtone text parser package
// Shared types, character codes, event codes and small helper functions.
// ----------------------------------------------------------------------------
package rtp_pkg;

   // Queue depths used as defaults for the top-level parameters.
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int RESULT_DEPTH_DEF = 2;

   // Reset values of the persistent settings.
   localparam logic [7:0] DEF_DURATION_RST = 8'd4;
   localparam logic [7:0] DEF_OCTAVE_RST   = 8'd5;
   localparam logic [7:0] TEMPO_RST        = 8'd1;

   // ASCII codes the parser reacts to.
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_C     = 8'h63;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_P     = 8'h70;

   // Event kinds on the result channel.
   localparam logic [1:0] EV_NOTE  = 2'd0;
   localparam logic [1:0] EV_PAUSE = 2'd1;
   localparam logic [1:0] EV_TEMPO = 2'd2;

   // Semitone numbers of the natural notes.
   localparam logic [3:0] SEMI_C = 4'd0;
   localparam logic [3:0] SEMI_D = 4'd2;
   localparam logic [3:0] SEMI_E = 4'd4;
   localparam logic [3:0] SEMI_F = 4'd5;
   localparam logic [3:0] SEMI_G = 4'd7;
   localparam logic [3:0] SEMI_A = 4'd9;
   localparam logic [3:0] SEMI_B = 4'd11;

   // Parser phases, one-hot.
   typedef enum logic [7:0] {
      PH_NAME   = 8'b0000_0001,
      PH_START  = 8'b0000_0010,
      PH_LETTER = 8'b0000_0100,
      PH_VALUE  = 8'b0000_1000,
      PH_SHARP  = 8'b0001_0000,
      PH_OCT    = 8'b0010_0000,
      PH_TAIL   = 8'b0100_0000,
      PH_VTAIL  = 8'b1000_0000
   } phase_type;

   // A classified text byte as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] char_in;
      logic       last;
      logic       is_space;
      logic       is_term;
      logic       is_colon;
      logic       is_digit;
      logic       is_equal;
      logic       is_sharp;
      logic       is_dot;
      logic [3:0] digit;
   } beat_type;

   // State of the token being parsed.
   typedef struct packed {
      logic [7:0] accum;
      logic [7:0] letter;
      logic [7:0] duration;
      logic [7:0] octave;
      logic       sharp;
      logic       dot;
      logic       have_number;
   } token_type;

   // One result event.
   typedef struct packed {
      logic [1:0] event_kind;
      logic [3:0] note_index;
      logic [7:0] octave;
      logic [7:0] duration;
      logic       dotted;
      logic [7:0] tempo_bpm;
   } event_type;

   // Decimal accumulation, value * 10 + digit, kept to eight bits.
   function automatic logic [7:0] acc10(input logic [7:0] v, input logic [3:0] d);
      acc10 = 8'((v << 3) + (v << 1) + {4'b0000, d});
   endfunction

endpackage

// ===== src/rtp_fifo.sv =====
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module rtp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   // Flags and handshakes.
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and count updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/rtp_front.sv =====
// ----------------------------------------------------------------------------
// Ringtone text parser front end
// Classifies each incoming text byte so the back end works from flags.
// ----------------------------------------------------------------------------
module rtp_front
   import rtp_pkg::*;
(
   input  logic [7:0] char_in,
   input  logic       last,
   output beat_type   beat
);

   // Character classes of the incoming byte.
   always_comb begin
      beat.char_in  = char_in;
      beat.last     = last;
      beat.is_space = (char_in == CH_SPACE);
      beat.is_colon = (char_in == CH_COLON);
      beat.is_term  = (char_in == CH_COMMA) || (char_in == CH_COLON);
      beat.is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
      beat.is_equal = (char_in == CH_EQUAL);
      beat.is_sharp = (char_in == CH_SHARP);
      beat.is_dot   = (char_in == CH_DOT);
      beat.digit    = 4'(char_in - CH_ZERO);
   end

endmodule

// ===== src/rtp_back.sv =====
// ----------------------------------------------------------------------------
// Ringtone text parser back end
// Runs the token state machine on classified bytes and produces events.
// ----------------------------------------------------------------------------
module rtp_back
   import rtp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      beat_valid,
   input  beat_type  beat,
   output logic      beat_take,
   input  logic      event_full,
   output logic      event_valid,
   output event_type event_data
);

   phase_type  phase_ff, phase_in, phase_mid;
   token_type  tok_ff, tok_in, tok_mid;
   logic [7:0] def_dur_ff, def_dur_in;
   logic [7:0] def_oct_ff, def_oct_in;
   logic [7:0] tempo_ff, tempo_in;
   logic       end_now;
   logic       is_odb;
   logic [3:0] semi;
   logic       sharp_ok;
   logic       note_known;
   logic       is_pause;

   // A byte is taken whenever one waits and the result queue has room.
   assign beat_take = beat_valid && !event_full;

   // Byte step: advances phase and token for one non-space byte.
   always_comb begin
      phase_mid = phase_ff;
      tok_mid   = tok_ff;
      is_odb    = (tok_ff.letter == CH_O) || (tok_ff.letter == CH_D) ||
                  (tok_ff.letter == CH_B);
      if (!beat.is_space) begin
         if (phase_ff == PH_NAME) begin
            if (beat.is_colon) begin
               phase_mid = PH_START;
            end
         end else if (!beat.is_term) begin
            unique case (phase_ff)
               PH_START: begin
                  if (beat.is_digit) begin
                     tok_mid.accum       = acc10(tok_ff.accum, beat.digit);
                     tok_mid.have_number = 1'b1;
                  end else begin
                     tok_mid.letter      = beat.char_in;
                     tok_mid.duration    = tok_ff.have_number ? tok_ff.accum : def_dur_ff;
                     tok_mid.octave      = def_oct_ff;
                     tok_mid.accum       = '0;
                     tok_mid.have_number = 1'b0;
                     phase_mid           = PH_LETTER;
                  end
               end
               PH_LETTER: begin
                  if (beat.is_equal) begin
                     if (is_odb) begin
                        tok_mid.accum = '0;
                        phase_mid     = PH_VALUE;
                     end else begin
                        tok_mid.letter = '0;
                        phase_mid      = PH_TAIL;
                     end
                  end else if (beat.is_sharp) begin
                     tok_mid.sharp = 1'b1;
                     phase_mid     = PH_SHARP;
                  end else if (beat.is_dot) begin
                     tok_mid.dot = 1'b1;
                     phase_mid   = PH_OCT;
                  end else if (beat.is_digit) begin
                     tok_mid.octave      = {4'b0000, beat.digit};
                     tok_mid.have_number = 1'b1;
                     phase_mid           = PH_OCT;
                  end else begin
                     phase_mid = PH_TAIL;
                  end
               end
               PH_SHARP: begin
                  if (beat.is_dot) begin
                     tok_mid.dot = 1'b1;
                     phase_mid   = PH_OCT;
                  end else if (beat.is_digit) begin
                     tok_mid.octave      = {4'b0000, beat.digit};
                     tok_mid.have_number = 1'b1;
                     phase_mid           = PH_OCT;
                  end else begin
                     phase_mid = PH_TAIL;
                  end
               end
               PH_OCT: begin
                  if (beat.is_digit) begin
                     tok_mid.octave = acc10(tok_ff.have_number ? tok_ff.octave : 8'd0,
                                            beat.digit);
                     tok_mid.have_number = 1'b1;
                  end else begin
                     phase_mid = PH_TAIL;
                  end
               end
               PH_VALUE: begin
                  if (beat.is_digit) begin
                     tok_mid.accum = acc10(tok_ff.accum, beat.digit);
                  end else begin
                     phase_mid = PH_VTAIL;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // The token ends on a separator, or on the final byte of the text.
   always_comb begin
      end_now = beat_take &&
                ((!beat.is_space && phase_ff != PH_NAME && beat.is_term) ||
                 (beat.last && phase_mid != PH_NAME));
   end

   // Note letter decoder.
   always_comb begin
      semi       = SEMI_C;
      sharp_ok   = 1'b1;
      note_known = 1'b1;
      is_pause   = 1'b0;
      unique case (tok_mid.letter)
         CH_C: semi = SEMI_C;
         CH_D: semi = SEMI_D;
         CH_E: begin
            semi     = SEMI_E;
            sharp_ok = 1'b0;
         end
         CH_F: semi = SEMI_F;
         CH_G: semi = SEMI_G;
         CH_A: semi = SEMI_A;
         CH_B: begin
            semi     = SEMI_B;
            sharp_ok = 1'b0;
         end
         CH_P: begin
            is_pause   = 1'b1;
            note_known = 1'b0;
         end
         default: note_known = 1'b0;
      endcase
   end

   // Token end: update settings and build the event.
   always_comb begin
      def_dur_in  = def_dur_ff;
      def_oct_in  = def_oct_ff;
      tempo_in    = tempo_ff;
      event_valid = 1'b0;
      event_data  = '0;
      if (end_now) begin
         if (phase_mid == PH_VALUE || phase_mid == PH_VTAIL) begin
            if (tok_mid.letter == CH_O) begin
               def_oct_in = tok_mid.accum;
            end else if (tok_mid.letter == CH_D) begin
               def_dur_in = tok_mid.accum;
            end else if (tok_mid.letter == CH_B) begin
               tempo_in             = tok_mid.accum;
               event_valid          = 1'b1;
               event_data.event_kind = EV_TEMPO;
               event_data.tempo_bpm  = tok_mid.accum;
            end
         end else if (phase_mid == PH_LETTER || phase_mid == PH_SHARP ||
                      phase_mid == PH_OCT || phase_mid == PH_TAIL) begin
            if (is_pause) begin
               event_valid           = 1'b1;
               event_data.event_kind = EV_PAUSE;
               event_data.duration   = tok_mid.duration;
               event_data.dotted     = tok_mid.dot;
            end else if (note_known) begin
               event_valid           = 1'b1;
               event_data.event_kind = EV_NOTE;
               event_data.note_index = semi + {3'b000, sharp_ok & tok_mid.sharp};
               event_data.octave     = tok_mid.octave;
               event_data.duration   = tok_mid.duration;
               event_data.dotted     = tok_mid.dot;
            end
         end
      end
   end

   // Next phase and token after the end of a token or of the text.
   always_comb begin
      phase_in = phase_ff;
      tok_in   = tok_ff;
      if (beat_take) begin
         phase_in = phase_mid;
         tok_in   = tok_mid;
         if (beat.last) begin
            phase_in = PH_NAME;
            tok_in   = '0;
         end else if (end_now) begin
            phase_in = PH_START;
            tok_in   = '0;
         end
      end
   end

   // Parser registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_NAME;
         tok_ff     <= '0;
         def_dur_ff <= DEF_DURATION_RST;
         def_oct_ff <= DEF_OCTAVE_RST;
         tempo_ff   <= TEMPO_RST;
      end else begin
         phase_ff   <= phase_in;
         tok_ff     <= tok_in;
         def_dur_ff <= def_dur_in;
         def_oct_ff <= def_oct_in;
         tempo_ff   <= tempo_in;
      end
   end

endmodule

// ===== src/ringtone_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// Ringtone text parser, top level
// Turns ringtone text, one byte per beat, into note, pause and tempo events.
//
// Use:
// - Input channel: drive req_char_in and req_last with req_push; a beat is
//   taken at a clock edge where req_push is high and req_full is low.
//   req_last marks the final byte of a text; the parser then goes back to
//   skipping a name section, keeping default duration, octave and tempo.
// - Result channel: while rsp_empty is low the oldest event is on the rsp_
//   ports; it is taken at an edge where rsp_pop is high.
// - Path: a taken byte is stored in the byte queue; the back end parses it
//   from there and writes its event into the result queue for popping.
// - Throughput: one byte per cycle while the result queue has room, as the
//   back end parses each byte in one combinational step.
// - Reset clears both queues and returns the parser to the name section
//   with duration 4, octave 5 and tempo 1.
// - A stalled receiver fills the result queue, the back end then holds,
//   and the byte queue fills until req_full rises.
// ----------------------------------------------------------------------------
module ringtone_text_parser_top
   import rtp_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
   parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_in,
   input  logic       req_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_event_kind,
   output logic [3:0] rsp_note_index,
   output logic [7:0] rsp_octave,
   output logic [7:0] rsp_duration,
   output logic       rsp_dotted,
   output logic [7:0] rsp_tempo_bpm
);

   beat_type  front_beat, queue_beat;
   logic      queue_empty;
   logic      beat_take;
   logic      result_full;
   logic      event_valid;
   event_type event_data, result_event;

   // Byte classification.
   rtp_front u_front (
      .char_in (req_char_in),
      .last    (req_last),
      .beat    (front_beat)
   );

   // Queue of classified bytes between front and back.
   rtp_fifo #(
      .WIDTH ($bits(beat_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_beat_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_beat),
      .full      (req_full),
      .pop       (beat_take),
      .pop_data  (queue_beat),
      .empty     (queue_empty)
   );

   // Parser state machine.
   rtp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (!queue_empty),
      .beat        (queue_beat),
      .beat_take   (beat_take),
      .event_full  (result_full),
      .event_valid (event_valid),
      .event_data  (event_data)
   );

   // Result queue toward the receiver.
   rtp_fifo #(
      .WIDTH ($bits(event_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (event_valid),
      .push_data (event_data),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_event),
      .empty     (rsp_empty)
   );

   assign rsp_event_kind = result_event.event_kind;
   assign rsp_note_index = result_event.note_index;
   assign rsp_octave     = result_event.octave;
   assign rsp_duration   = result_event.duration;
   assign rsp_dotted     = result_event.dotted;
   assign rsp_tempo_bpm  = result_event.tempo_bpm;

   // The back end only produces an event for a byte it takes, with room left.
   assert property (@(posedge clock) disable iff (reset)
      event_valid |-> (beat_take && !result_full))
      else $error("event produced without a taken byte or with the result queue full");

   // After reset no result is offered.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result offered right after reset");

   // Event kinds stay within the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      event_valid |-> (event_data.event_kind == EV_NOTE ||
                       event_data.event_kind == EV_PAUSE ||
                       event_data.event_kind == EV_TEMPO))
      else $error("undefined event kind produced");

   // Note events carry a semitone within the octave.
   assert property (@(posedge clock) disable iff (reset)
      (event_valid && event_data.event_kind == EV_NOTE) |->
         (event_data.note_index <= SEMI_B))
      else $error("note index out of range");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Ringtone text parser testbench
// Sends ringtone text to the parser one byte per beat and checks every
// note, pause and tempo event against a parser model kept in the bench.
// A short directed table comes first, then random songs, mostly well
// formed, with noise and broken tokens mixed in. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module testbench;
   import rtp_pkg::*;

   localparam int RANDOM_BYTES = 700;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;

   // One row of the directed table; typed rows carry their event by hand.
   typedef struct {
      logic [7:0] ch;
      logic       fin;
      bit         typed;
      event_type  ev;
   } text_row_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic [7:0] req_char_in = 8'h00;
   logic       req_last    = 1'b0;
   logic       rsp_pop     = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [1:0] rsp_event_kind;
   logic [3:0] rsp_note_index;
   logic [7:0] rsp_octave;
   logic [7:0] rsp_duration;
   logic       rsp_dotted;
   logic [7:0] rsp_tempo_bpm;

   // Events still owed by the parser, oldest first.
   event_type  events_due[$];
   logic [7:0] song_q[$];
   int         error_count = 0;
   int         bytes_sent  = 0;
   int         cycle_count = 0;
   int         pop_hold    = 0;
   bit         calm        = 1'b0;

   // Parser model state.
   phase_type  mdl_phase;
   logic [7:0] mdl_def_dur;
   logic [7:0] mdl_def_oct;
   logic [7:0] mdl_bpm;
   logic [7:0] mdl_accum;
   logic [7:0] mdl_letter;
   logic [7:0] mdl_dur;
   logic [7:0] mdl_oct;
   logic       mdl_sharp;
   logic       mdl_dot;
   logic       mdl_num;

   ringtone_text_parser_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_in    (req_char_in),
      .req_last       (req_last),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_event_kind (rsp_event_kind),
      .rsp_note_index (rsp_note_index),
      .rsp_octave     (rsp_octave),
      .rsp_duration   (rsp_duration),
      .rsp_dotted     (rsp_dotted),
      .rsp_tempo_bpm  (rsp_tempo_bpm)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic bit is_num_char(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // Decimal digit accumulation, wrapping at eight bits.
   function automatic logic [7:0] shift_in_digit(input logic [7:0] v, input logic [7:0] c);
      logic [7:0] d;
      d = c - CH_ZERO;
      return v * 8'd10 + d;
   endfunction

   task automatic wipe_token();
      mdl_accum  = 8'd0;
      mdl_letter = 8'd0;
      mdl_dur    = 8'd0;
      mdl_oct    = 8'd0;
      mdl_sharp  = 1'b0;
      mdl_dot    = 1'b0;
      mdl_num    = 1'b0;
   endtask

   // Closes the open token: settings update the defaults (a tempo also gives an event), notes and pauses become events.
   task automatic close_token(output logic got, output event_type ev);
      logic [3:0] semi;
      bit         is_note;
      got     = 1'b0;
      ev      = '0;
      is_note = 1'b1;
      semi    = 4'd0;
      if (mdl_phase == PH_VALUE || mdl_phase == PH_VTAIL) begin
         case (mdl_letter)
            CH_O: mdl_def_oct = mdl_accum;
            CH_D: mdl_def_dur = mdl_accum;
            CH_B: begin
               mdl_bpm      = mdl_accum;
               got          = 1'b1;
               ev.event_kind = EV_TEMPO;
               ev.tempo_bpm = mdl_bpm;
            end
            default: ;
         endcase
      end else if (mdl_phase == PH_LETTER || mdl_phase == PH_SHARP ||
                   mdl_phase == PH_OCT || mdl_phase == PH_TAIL) begin
         case (mdl_letter)
            CH_C: semi = SEMI_C + mdl_sharp;
            CH_D: semi = SEMI_D + mdl_sharp;
            CH_E: semi = SEMI_E;
            CH_F: semi = SEMI_F + mdl_sharp;
            CH_G: semi = SEMI_G + mdl_sharp;
            CH_A: semi = SEMI_A + mdl_sharp;
            CH_B: semi = SEMI_B;
            default: is_note = 1'b0;
         endcase
         if (mdl_letter == CH_P) begin
            got          = 1'b1;
            ev.event_kind = EV_PAUSE;
            ev.duration  = mdl_dur;
            ev.dotted    = mdl_dot;
         end else if (is_note) begin
            got          = 1'b1;
            ev.event_kind = EV_NOTE;
            ev.note_index = semi;
            ev.octave    = mdl_oct;
            ev.duration  = mdl_dur;
            ev.dotted    = mdl_dot;
         end
      end
      wipe_token();
      mdl_phase = PH_START;
   endtask

   // Advances the model by one text byte and returns the event it causes.
   task automatic parse_char(input logic [7:0] c, input logic fin,
                             output logic got, output event_type ev);
      got = 1'b0;
      ev  = '0;
      if (c != CH_SPACE) begin
         if (mdl_phase == PH_NAME) begin
            if (c == CH_COLON) mdl_phase = PH_START;
         end else if (c == CH_COMMA || c == CH_COLON) begin
            close_token(got, ev);
         end else begin
            case (mdl_phase)
               PH_START: begin
                  if (is_num_char(c)) begin
                     mdl_accum = shift_in_digit(mdl_accum, c);
                     mdl_num   = 1'b1;
                  end else begin
                     mdl_letter = c;
                     mdl_dur    = mdl_num ? mdl_accum : mdl_def_dur;
                     mdl_oct    = mdl_def_oct;
                     mdl_accum  = 8'd0;
                     mdl_num    = 1'b0;
                     mdl_phase  = PH_LETTER;
                  end
               end
               PH_LETTER: begin
                  if (c == CH_EQUAL) begin
                     if (mdl_letter == CH_O || mdl_letter == CH_D || mdl_letter == CH_B) begin
                        mdl_accum = 8'd0;
                        mdl_phase = PH_VALUE;
                     end else begin
                        mdl_letter = 8'd0;
                        mdl_phase  = PH_TAIL;
                     end
                  end else if (c == CH_SHARP) begin
                     mdl_sharp = 1'b1;
                     mdl_phase = PH_SHARP;
                  end else if (c == CH_DOT) begin
                     mdl_dot   = 1'b1;
                     mdl_phase = PH_OCT;
                  end else if (is_num_char(c)) begin
                     mdl_oct   = shift_in_digit(8'd0, c);
                     mdl_num   = 1'b1;
                     mdl_phase = PH_OCT;
                  end else begin
                     mdl_phase = PH_TAIL;
                  end
               end
               PH_SHARP: begin
                  if (c == CH_DOT) begin
                     mdl_dot   = 1'b1;
                     mdl_phase = PH_OCT;
                  end else if (is_num_char(c)) begin
                     mdl_oct   = shift_in_digit(8'd0, c);
                     mdl_num   = 1'b1;
                     mdl_phase = PH_OCT;
                  end else begin
                     mdl_phase = PH_TAIL;
                  end
               end
               PH_OCT: begin
                  if (is_num_char(c)) begin
                     mdl_oct = shift_in_digit(mdl_num ? mdl_oct : 8'd0, c);
                     mdl_num = 1'b1;
                  end else begin
                     mdl_phase = PH_TAIL;
                  end
               end
               PH_VALUE: begin
                  if (is_num_char(c)) mdl_accum = shift_in_digit(mdl_accum, c);
                  else mdl_phase = PH_VTAIL;
               end
               default: ;
            endcase
         end
      end
      // The final byte closes any open token and rewinds to the name section.
      if (fin) begin
         if (mdl_phase != PH_NAME && !got) close_token(got, ev);
         wipe_token();
         mdl_phase = PH_NAME;
      end
   endtask

   // Idle stretch length: mostly short, now and then long.
   function automatic int pick_pause();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // Sends one byte as a beat and books the event it should cause.
   task automatic send_char(input logic [7:0] c, input logic fin,
                            input bit typed, input event_type typed_ev);
      int        gap;
      logic      got;
      event_type ev;
      gap = (!calm && $urandom_range(0, 99) < 35) ? pick_pause() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_char_in <= c;
      req_last    <= fin;
      req_push    <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      parse_char(c, fin, got, ev);
      if (typed) events_due.push_back(typed_ev);
      else if (got) events_due.push_back(ev);
      bytes_sent++;
   endtask

   // Appends a byte to the song, sometimes with a stray space in front.
   task automatic put_byte(input logic [7:0] b);
      if ($urandom_range(0, 19) == 0) song_q.push_back(CH_SPACE);
      song_q.push_back(b);
   endtask

   task automatic put_num(input int n);
      string s;
      s = $sformatf("%0d", n);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   // Mostly small musical numbers, some full byte range, a few that wrap.
   function automatic int pick_num();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(1, 32);
      if (r < 8) return $urandom_range(0, 255);
      if (r < 9) return $urandom_range(0, 9);
      return $urandom_range(256, 99999);
   endfunction

   function automatic logic [7:0] pick_letter();
      string notes;
      int    r;
      notes = "abcdefgp";
      r = $urandom_range(0, 15);
      if (r < 14) return notes[$urandom_range(0, 7)];
      if (r == 14) return CH_O;
      return 8'($urandom_range(0, 255));
   endfunction

   // Builds one song (or a burst of noise) and sends it byte by byte.
   task automatic send_song();
      string keys;
      bit    first;
      int    n;
      song_q.delete();
      keys = "dob";
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
         // Noise: arbitrary bytes, sometimes not even closed by a final byte.
         n = $urandom_range(1, 16);
         repeat (n) song_q.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) == 0) song_q.insert($urandom_range(0, n - 1), CH_COLON);
      end else begin
         // Name section.
         n = $urandom_range(0, 6);
         repeat (n) begin
            logic [7:0] b;
            b = 8'($urandom_range(0, 255));
            put_byte(b == CH_COLON ? CH_SPACE : b);
         end
         put_byte(CH_COLON);
         // Default settings, in any subset.
         first = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 2) != 0) begin
               if (!first) put_byte(CH_COMMA);
               first = 1'b0;
               put_byte(keys[i]);
               put_byte(CH_EQUAL);
               if ($urandom_range(0, 9) != 0) put_num(pick_num());
               if ($urandom_range(0, 9) == 0) begin
                  put_byte("x");
                  put_num($urandom_range(0, 99));
               end
            end
         end
         put_byte(CH_COLON);
         // Note tokens.
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) begin
            if (i > 0) put_byte($urandom_range(0, 19) == 0 ? CH_COLON : CH_COMMA);
            if ($urandom_range(0, 1)) put_num(pick_num());
            put_byte(pick_letter());
            if ($urandom_range(0, 3) == 0) put_byte(CH_SHARP);
            if ($urandom_range(0, 3) == 0) put_byte(CH_DOT);
            if ($urandom_range(0, 1))
               put_num($urandom_range(0, 3) == 0 ? pick_num() : $urandom_range(3, 7));
            if ($urandom_range(0, 9) == 0)
               put_byte($urandom_range(0, 2) == 0 ? CH_DOT : pick_letter());
         end
         if ($urandom_range(0, 4) == 0) put_byte(CH_COMMA);
         // Broken songs: a few bytes replaced by arbitrary ones.
         foreach (song_q[i])
            if ($urandom_range(0, 49) == 0) song_q[i] = 8'($urandom_range(0, 255));
      end
      foreach (song_q[i]) begin
         logic fin;
         fin = (i == song_q.size() - 1) && ($urandom_range(0, 7) != 0);
         send_char(song_q[i], fin, 1'b0, '0);
      end
   endtask

   // Stimulus: reset, directed table, random songs, then drain.
   initial begin
      text_row_type plan[$];
      mdl_phase   = PH_NAME;
      mdl_def_dur = DEF_DURATION_RST;
      mdl_def_oct = DEF_OCTAVE_RST;
      mdl_bpm     = TEMPO_RST;
      wipe_token();

      // Name byte at the top of the range, then the first colon.
      plan.push_back('{8'hFF, 1'b0, 1'b0, '0});
      plan.push_back('{CH_COLON, 1'b0, 1'b0, '0});
      // Tempo at its largest value.
      plan.push_back('{CH_B, 1'b0, 1'b0, '0});
      plan.push_back('{CH_EQUAL, 1'b0, 1'b0, '0});
      plan.push_back('{"2", 1'b0, 1'b0, '0});
      plan.push_back('{"5", 1'b0, 1'b0, '0});
      plan.push_back('{"5", 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b1,
                       event_type'{EV_TEMPO, 4'd0, 8'd0, 8'd0, 1'b0, 8'd255}});
      // Default octave.
      plan.push_back('{CH_O, 1'b0, 1'b0, '0});
      plan.push_back('{CH_EQUAL, 1'b0, 1'b0, '0});
      plan.push_back('{"7", 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b0, '0});
      // Full note: duration, sharp, dot and octave.
      plan.push_back('{"3", 1'b0, 1'b0, '0});
      plan.push_back('{"2", 1'b0, 1'b0, '0});
      plan.push_back('{CH_C, 1'b0, 1'b0, '0});
      plan.push_back('{CH_SHARP, 1'b0, 1'b0, '0});
      plan.push_back('{CH_DOT, 1'b0, 1'b0, '0});
      plan.push_back('{"6", 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b0, '0});
      // Pause with the default duration.
      plan.push_back('{CH_P, 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b1,
                       event_type'{EV_PAUSE, 4'd0, 8'd0, 8'd4, 1'b0, 8'd0}});
      // Unknown uppercase letter discards its token.
      plan.push_back('{"X", 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b0, '0});
      // Sharp on e is ignored.
      plan.push_back('{CH_E, 1'b0, 1'b0, '0});
      plan.push_back('{CH_SHARP, 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b0, '0});
      // Empty value sets the default duration to zero.
      plan.push_back('{CH_D, 1'b0, 1'b0, '0});
      plan.push_back('{CH_EQUAL, 1'b0, 1'b0, '0});
      plan.push_back('{CH_COMMA, 1'b0, 1'b0, '0});
      // Final byte closes a bare note.
      plan.push_back('{CH_B, 1'b1, 1'b1,
                       event_type'{EV_NOTE, SEMI_B, 8'd7, 8'd0, 1'b0, 8'd0}});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_char(plan[i].ch, plan[i].fin, plan[i].typed, plan[i].ev);
      while (bytes_sent < plan.size() + RANDOM_BYTES) send_song();
      req_push <= 1'b0;

      while (events_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // Receiver: pops with random stalls, none started while the song is calm.
   always @(posedge clock) begin
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         pop_hold <= pick_pause() - 1;
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Checks each popped event against the oldest one owed.
   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (events_due.size() == 0) begin
            report_mismatch("unexpected event, kind", rsp_event_kind, -1);
         end else begin
            want = events_due.pop_front();
            if (rsp_event_kind != want.event_kind)
               report_mismatch("event_kind", rsp_event_kind, want.event_kind);
            if (rsp_note_index != want.note_index)
               report_mismatch("note_index", rsp_note_index, want.note_index);
            if (rsp_octave != want.octave)
               report_mismatch("octave", rsp_octave, want.octave);
            if (rsp_duration != want.duration)
               report_mismatch("duration", rsp_duration, want.duration);
            if (rsp_dotted != want.dotted)
               report_mismatch("dotted", rsp_dotted, want.dotted);
            if (rsp_tempo_bpm != want.tempo_bpm)
               report_mismatch("tempo_bpm", rsp_tempo_bpm, want.tempo_bpm);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

// ===== ringtone_text_parser_top.f =====
src/rtp_pkg.sv
src/rtp_fifo.sv
src/rtp_front.sv
src/rtp_back.sv
src/ringtone_text_parser_top.sv
sim/testbench.sv
